FILE: design/fpa_pkg.sv
// Package for the variable-partition allocator: table sizes, request codes, status codes.
// No dependencies.
package fpa_pkg;
  localparam int MaxSegs  = 32;
  localparam int AddrBits = 16;
  localparam int IdxW     = $clog2(MaxSegs);
  localparam int CntW     = $clog2(MaxSegs + 1);

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [CntW-1:0]     cnt_t;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_NOID    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic CFG_FIT_MODE = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  localparam logic [15:0] CapacityReset = 16'd640;
endpackage

FILE: design/fit_partition_allocator_top.sv
// Top level of the variable-partition allocator: segment table, sequencer, result register.
// Depends on fpa_pkg.
//
// A search walks the table one entry per cycle through one shared compare unit,
// then a split or merge moves one entry per cycle. Throughput: one request at a
// time, in_stall stays high until the result is taken. Reset (synchronous, rst_n
// low): fit_mode 0, capacity 640, one free segment, count 1.
module fit_partition_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_owner_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_granted_id,
  output logic [15:0] out_base_addr,
  output logic [15:0] out_seg_length,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import fpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SPLIT, S_SHIFTUP, S_FREE, S_MERGE, S_SHIFTDN, S_DONE
  } state_t;

  // segment table; one entry per register row, handled by one shifting unit
  addr_t       seg_base_r  [MaxSegs];
  addr_t       seg_size_r  [MaxSegs];
  logic [15:0] seg_owner_r [MaxSegs];
  logic [MaxSegs-1:0] seg_used_r;
  cnt_t        seg_count_r;
  logic [15:0] next_owner_r;
  logic        fit_mode_r;
  logic [15:0] capacity_r;

  state_t      state_r;
  addr_t       req_r;
  logic [15:0] id_r;
  cnt_t        ptr_r;    // scan / shift pointer
  idx_t        pick_r;
  logic        found_r;
  logic        out_valid_r;
  logic [2:0]  st_r;
  logic [15:0] gid_r, base_r, len_r;

  idx_t ptr_idx;
  logic in_take;
  logic fits;
  assign ptr_idx = ptr_r[IdxW-1:0];
  assign in_take = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  // shared compare unit: one entry per cycle
  assign fits = !seg_used_r[ptr_idx] && (seg_size_r[ptr_idx] >= req_r);

  assign out_valid      = out_valid_r;
  assign out_status     = st_r;
  assign out_granted_id = gid_r;
  assign out_base_addr  = base_r;
  assign out_seg_length = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fit_mode_r  <= 1'b0;
      capacity_r  <= CapacityReset;
      seg_count_r <= cnt_t'(1);
      next_owner_r <= '0;
      seg_used_r  <= '0;
      seg_base_r[0] <= '0;
      seg_size_r[0] <= addr_t'(CapacityReset);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIT_MODE: fit_mode_r <= cfg_wdata[0];
          CFG_CAPACITY: capacity_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            req_r   <= addr_t'(in_req_size);
            id_r    <= in_owner_id;
            ptr_r   <= '0;
            found_r <= 1'b0;
            gid_r   <= '0;
            base_r  <= '0;
            len_r   <= '0;
            st_r    <= ST_BAD;
            case (in_func)
              FUNC_ALLOC: state_r <= (in_req_size == '0) ? S_DONE : S_SCAN;
              FUNC_FREE:  state_r <= (in_owner_id == '0) ? S_DONE : S_FREE;
              FUNC_CLEAR: begin
                seg_used_r    <= '0;
                seg_base_r[0] <= '0;
                seg_size_r[0] <= addr_t'(capacity_r);
                seg_count_r   <= cnt_t'(1);
                next_owner_r  <= '0;
                st_r  <= ST_OK;
                len_r <= 16'(addr_t'(capacity_r));
                state_r <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          // walk entries; first fit stops at the first hit, best fit keeps strict minimum
          if (ptr_r >= seg_count_r) begin
            if (!found_r) begin
              st_r <= ST_NOFIT;
              state_r <= S_DONE;
            end else begin
              state_r <= S_SPLIT;
            end
          end else begin
            if (fits && (!found_r || (fit_mode_r && seg_size_r[ptr_idx] < seg_size_r[pick_r])))
            begin
              pick_r  <= ptr_idx;
              found_r <= 1'b1;
              if (!fit_mode_r) state_r <= S_SPLIT;
            end
            ptr_r <= ptr_r + cnt_t'(1);
          end
        end
        S_SPLIT: begin
          if (seg_size_r[pick_r] == req_r) begin
            seg_used_r[pick_r]  <= 1'b1;
            seg_owner_r[pick_r] <= next_owner_r;
            next_owner_r <= next_owner_r + 16'd1;
            st_r  <= ST_OK;
            gid_r <= next_owner_r;
            base_r <= 16'(seg_base_r[pick_r]);
            len_r  <= 16'(req_r);
            state_r <= S_DONE;
          end else if (seg_count_r >= cnt_t'(MaxSegs)) begin
            st_r <= ST_FULL;
            state_r <= S_DONE;
          end else begin
            ptr_r <= seg_count_r;
            state_r <= S_SHIFTUP;
          end
        end
        S_SHIFTUP: begin
          // open a hole after pick, one entry per cycle from the top
          if (ptr_r > cnt_t'(pick_r) + cnt_t'(1)) begin
            seg_base_r[ptr_idx]  <= seg_base_r[ptr_idx - idx_t'(1)];
            seg_size_r[ptr_idx]  <= seg_size_r[ptr_idx - idx_t'(1)];
            seg_used_r[ptr_idx]  <= seg_used_r[ptr_idx - idx_t'(1)];
            seg_owner_r[ptr_idx] <= seg_owner_r[ptr_idx - idx_t'(1)];
            ptr_r <= ptr_r - cnt_t'(1);
          end else begin
            seg_base_r[ptr_idx]  <= seg_base_r[pick_r] + req_r;
            seg_size_r[ptr_idx]  <= seg_size_r[pick_r] - req_r;
            seg_used_r[ptr_idx]  <= 1'b0;
            seg_size_r[pick_r]   <= req_r;
            seg_count_r <= seg_count_r + cnt_t'(1);
            state_r <= S_SPLIT;
          end
        end
        S_FREE: begin
          if (ptr_r >= seg_count_r) begin
            st_r <= ST_NOID;
            state_r <= S_DONE;
          end else if (seg_used_r[ptr_idx] && seg_owner_r[ptr_idx] == id_r) begin
            seg_used_r[ptr_idx] <= 1'b0;
            pick_r <= ptr_idx;
            found_r <= 1'b0;  // reused: right-side merge done
            state_r <= S_MERGE;
          end else begin
            ptr_r <= ptr_r + cnt_t'(1);
          end
        end
        S_MERGE: begin
          // left merge first, then right; each merge closes a hole by shifting down
          if (!found_r && pick_r != '0 && !seg_used_r[pick_r - idx_t'(1)]) begin
            seg_size_r[pick_r - idx_t'(1)] <=
              seg_size_r[pick_r - idx_t'(1)] + seg_size_r[pick_r];
            ptr_r  <= cnt_t'(pick_r);
            pick_r <= pick_r - idx_t'(1);
            state_r <= S_SHIFTDN;
          end else if (!found_r && cnt_t'(pick_r) + cnt_t'(1) < seg_count_r
                       && !seg_used_r[pick_r + idx_t'(1)]) begin
            seg_size_r[pick_r] <= seg_size_r[pick_r] + seg_size_r[pick_r + idx_t'(1)];
            ptr_r   <= cnt_t'(pick_r) + cnt_t'(1);
            found_r <= 1'b1;
            state_r <= S_SHIFTDN;
          end else begin
            st_r   <= ST_OK;
            base_r <= 16'(seg_base_r[pick_r]);
            len_r  <= 16'(seg_size_r[pick_r]);
            state_r <= S_DONE;
          end
        end
        S_SHIFTDN: begin
          if (ptr_r + cnt_t'(1) < seg_count_r) begin
            seg_base_r[ptr_idx]  <= seg_base_r[ptr_idx + idx_t'(1)];
            seg_size_r[ptr_idx]  <= seg_size_r[ptr_idx + idx_t'(1)];
            seg_used_r[ptr_idx]  <= seg_used_r[ptr_idx + idx_t'(1)];
            seg_owner_r[ptr_idx] <= seg_owner_r[ptr_idx + idx_t'(1)];
            ptr_r <= ptr_r + cnt_t'(1);
          end else begin
            seg_count_r <= seg_count_r - cnt_t'(1);
            state_r <= S_MERGE;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // table never empty and never beyond its depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    seg_count_r >= cnt_t'(1) && seg_count_r <= cnt_t'(MaxSegs))
    else $error("segment count out of range");
  // a result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(st_r))
    else $error("result dropped under stall");
  // no request taken while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall)
    else $error("request accepted with result pending");
  // errors carry zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_r != ST_OK |-> base_r == '0 && len_r == '0 && gid_r == '0)
    else $error("error result with nonzero payload");
endmodule
